// ===== src/c2c_pkg.sv =====
// Shared constants and types for the COO to CSR converter.
// Used by the core; depends on nothing else.
package c2c_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_NNZ  = 4096;

  localparam int MODE_W = 3;
  localparam int STAT_W = 3;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 16;
  localparam int VAL_W  = 64;
  localparam int POS_W  = 13;
  localparam int NR_W   = 11;
  localparam int CNT_W  = $clog2(MAX_NNZ + 1);

  localparam int RP_DEPTH = MAX_ROWS + 1;
  localparam int RP_AW    = $clog2(RP_DEPTH);
  localparam int NNZ_AW   = $clog2(MAX_NNZ);
  localparam int COO_W    = ROW_W + COL_W + VAL_W;
  localparam int CSR_W    = COL_W + VAL_W;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam mode_t MODE_LOAD   = 3'd0;
  localparam mode_t MODE_BUILD  = 3'd1;
  localparam mode_t MODE_RD_RP  = 3'd2;
  localparam mode_t MODE_RD_CSR = 3'd3;
  localparam mode_t MODE_CLEAR  = 3'd4;

  localparam stat_t ST_OK    = 3'd0;
  localparam stat_t ST_ROW   = 3'd1;
  localparam stat_t ST_FULL  = 3'd2;
  localparam stat_t ST_POS   = 3'd3;
  localparam stat_t ST_PHASE = 3'd4;

endpackage

// ===== src/c2c_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module c2c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/coo_to_csr_converter_core.sv =====
// Top level of the COO to CSR converter: sequencer, counters and four RAMs.
// Depends on c2c_pkg and c2c_ram.
//
// Usage: items enter on the in_ channel (valid/ready) and each gives exactly one
// result item on the out_ channel (valid/ready). An item is taken only while the
// sequencer is idle; a finished result sits in the output register, so the next
// item can be taken while that result still waits for out_ready.
// Steps per item, from accept until the next item can be accepted:
//   loads and both reads: one RAM read, one RAM write or capture, and a move
//   of the result into the output register;
//   items rejected with an error status: only the move into the output register;
//   build: set by the single row-pointer adder (read then accumulate per row)
//   and by the three-step scatter per entry (triplet read, next-slot read, CSR
//   and next-slot write);
//   clear: every row-pointer entry zeroed, one entry per cycle.
// After reset the block runs the same clearing pass over the row pointers and
// holds in_ready low until done; cfg_wr_en acts only on an empty, unbuilt store.
// If out_ready stays low, a finished item waits in the sequencer and in_ready
// stays low until the output register frees up.
// num_rows only changes while the store is empty and not built.
module coo_to_csr_converter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [c2c_pkg::NR_W-1:0]    cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  c2c_pkg::mode_t              in_mode,
  input  logic [c2c_pkg::ROW_W-1:0]   in_row_index,
  input  logic [c2c_pkg::COL_W-1:0]   in_col_index,
  input  logic [c2c_pkg::VAL_W-1:0]   in_value,
  input  logic [c2c_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output c2c_pkg::stat_t              out_status,
  output logic [c2c_pkg::POS_W-1:0]   out_row_pointer,
  output logic [c2c_pkg::COL_W-1:0]   out_column,
  output logic [c2c_pkg::VAL_W-1:0]   out_value,
  output logic [c2c_pkg::CNT_W-1:0]   out_entry_total
);
  import c2c_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LD_WR  = 4'd2;
  localparam logic [3:0] S_PS_RD  = 4'd3;
  localparam logic [3:0] S_PS_WR  = 4'd4;
  localparam logic [3:0] S_SC_RD  = 4'd5;
  localparam logic [3:0] S_SC_NS  = 4'd6;
  localparam logic [3:0] S_SC_WR  = 4'd7;
  localparam logic [3:0] S_RD_RP  = 4'd8;
  localparam logic [3:0] S_RD_CSR = 4'd9;
  localparam logic [3:0] S_CLR    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic             built_r, built_nxt;
  logic [NR_W-1:0]  num_rows_r, num_rows_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CSR_W-1:0] pay_r, pay_nxt;

  stat_t            res_status_r, res_status_nxt;
  logic [POS_W-1:0] res_rp_r, res_rp_nxt;
  logic [COL_W-1:0] res_col_r, res_col_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;

  logic             out_valid_r, out_valid_nxt;
  stat_t            out_status_r;
  logic [POS_W-1:0] out_rp_r;
  logic [COL_W-1:0] out_col_r;
  logic [VAL_W-1:0] out_val_r;
  logic [CNT_W-1:0] out_total_r;
  logic             out_load;

  logic [NR_W-1:0]  rows;
  logic [CNT_W-1:0] sum;
  logic             accept;

  logic              coo_we;
  logic [NNZ_AW-1:0] coo_waddr, coo_raddr;
  logic [COO_W-1:0]  coo_wdata, coo_rdata;
  logic              rp_we;
  logic [RP_AW-1:0]  rp_waddr, rp_raddr;
  logic [CNT_W-1:0]  rp_wdata, rp_rdata;
  logic              ns_we;
  logic [RP_AW-1:0]  ns_waddr, ns_raddr;
  logic [CNT_W-1:0]  ns_wdata, ns_rdata;
  logic              csr_we;
  logic [NNZ_AW-1:0] csr_waddr, csr_raddr;
  logic [CSR_W-1:0]  csr_wdata, csr_rdata;

  c2c_ram #(.WIDTH(COO_W), .DEPTH(MAX_NNZ)) u_coo_ram (
    .clk(clk), .wr_en(coo_we), .wr_addr(coo_waddr), .wr_data(coo_wdata),
    .rd_addr(coo_raddr), .rd_data(coo_rdata)
  );

  c2c_ram #(.WIDTH(CNT_W), .DEPTH(RP_DEPTH)) u_rp_ram (
    .clk(clk), .wr_en(rp_we), .wr_addr(rp_waddr), .wr_data(rp_wdata),
    .rd_addr(rp_raddr), .rd_data(rp_rdata)
  );

  c2c_ram #(.WIDTH(CNT_W), .DEPTH(RP_DEPTH)) u_ns_ram (
    .clk(clk), .wr_en(ns_we), .wr_addr(ns_waddr), .wr_data(ns_wdata),
    .rd_addr(ns_raddr), .rd_data(ns_rdata)
  );

  c2c_ram #(.WIDTH(CSR_W), .DEPTH(MAX_NNZ)) u_csr_ram (
    .clk(clk), .wr_en(csr_we), .wr_addr(csr_waddr), .wr_data(csr_wdata),
    .rd_addr(csr_raddr), .rd_data(csr_rdata)
  );

  assign rows     = (num_rows_r > NR_W'(MAX_ROWS)) ? NR_W'(MAX_ROWS) : num_rows_r;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign sum      = rp_rdata + acc_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    acc_nxt         = acc_r;
    entry_count_nxt = entry_count_r;
    built_nxt       = built_r;
    row_nxt         = row_r;
    pay_nxt         = pay_r;
    res_status_nxt  = res_status_r;
    res_rp_nxt      = res_rp_r;
    res_col_nxt     = res_col_r;
    res_val_nxt     = res_val_r;
    out_load        = 1'b0;

    coo_we    = 1'b0;
    coo_waddr = entry_count_r[NNZ_AW-1:0];
    coo_wdata = {in_row_index, in_col_index, in_value};
    coo_raddr = cnt_r[NNZ_AW-1:0];
    rp_we     = 1'b0;
    rp_waddr  = cnt_r[RP_AW-1:0];
    rp_wdata  = '0;
    rp_raddr  = cnt_r[RP_AW-1:0];
    ns_we     = 1'b0;
    ns_waddr  = cnt_r[RP_AW-1:0];
    ns_wdata  = sum;
    ns_raddr  = RP_AW'(coo_rdata[COO_W-1 -: ROW_W]);
    csr_we    = 1'b0;
    csr_waddr = ns_rdata[NNZ_AW-1:0];
    csr_wdata = pay_r;
    csr_raddr = in_position[NNZ_AW-1:0];

    case (state_r)
      S_INIT, S_CLR: begin
        // Zero one row-pointer entry per cycle.
        rp_we = 1'b1;
        if (cnt_r == CNT_W'(RP_DEPTH - 1)) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_OK;
          res_rp_nxt     = '0;
          res_col_nxt    = '0;
          res_val_nxt    = '0;
          state_nxt      = S_FIN;
          case (in_mode)
            MODE_LOAD: begin
              if (built_r) begin
                res_status_nxt = ST_PHASE;
              end else if (NR_W'(in_row_index) >= rows) begin
                res_status_nxt = ST_ROW;
              end else if (entry_count_r >= CNT_W'(MAX_NNZ)) begin
                res_status_nxt = ST_FULL;
              end else begin
                coo_we    = 1'b1;
                rp_raddr  = RP_AW'(in_row_index) + RP_AW'(1);
                row_nxt   = in_row_index;
                state_nxt = S_LD_WR;
              end
            end
            MODE_BUILD: begin
              if (built_r) begin
                res_status_nxt = ST_PHASE;
              end else begin
                ns_we     = 1'b1;
                ns_waddr  = '0;
                ns_wdata  = '0;
                acc_nxt   = '0;
                cnt_nxt   = CNT_W'(1);
                state_nxt = S_PS_RD;
              end
            end
            MODE_RD_RP: begin
              if (!built_r) begin
                res_status_nxt = ST_PHASE;
              end else if (in_position > POS_W'(rows)) begin
                res_status_nxt = ST_POS;
              end else begin
                rp_raddr  = in_position[RP_AW-1:0];
                state_nxt = S_RD_RP;
              end
            end
            MODE_RD_CSR: begin
              if (!built_r) begin
                res_status_nxt = ST_PHASE;
              end else if (in_position >= entry_count_r) begin
                res_status_nxt = ST_POS;
              end else begin
                state_nxt = S_RD_CSR;
              end
            end
            MODE_CLEAR: begin
              cnt_nxt         = '0;
              entry_count_nxt = '0;
              built_nxt       = 1'b0;
              state_nxt       = S_CLR;
            end
            default: begin
              res_status_nxt = ST_PHASE;
            end
          endcase
        end
      end
      S_LD_WR: begin
        rp_we           = 1'b1;
        rp_waddr        = RP_AW'(row_r) + RP_AW'(1);
        rp_wdata        = rp_rdata + 1'b1;
        entry_count_nxt = entry_count_r + 1'b1;
        state_nxt       = S_FIN;
      end
      S_PS_RD: begin
        if (cnt_r > CNT_W'(rows)) begin
          cnt_nxt   = '0;
          state_nxt = S_SC_RD;
        end else begin
          state_nxt = S_PS_WR;
        end
      end
      S_PS_WR: begin
        // Running prefix sum; the next-slot table starts as a copy of it.
        rp_we     = 1'b1;
        rp_wdata  = sum;
        ns_we     = 1'b1;
        acc_nxt   = sum;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_PS_RD;
      end
      S_SC_RD: begin
        if (cnt_r >= entry_count_r) begin
          built_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SC_NS;
        end
      end
      S_SC_NS: begin
        row_nxt   = coo_rdata[COO_W-1 -: ROW_W];
        pay_nxt   = coo_rdata[CSR_W-1:0];
        state_nxt = S_SC_WR;
      end
      S_SC_WR: begin
        csr_we    = 1'b1;
        ns_we     = 1'b1;
        ns_waddr  = RP_AW'(row_r);
        ns_wdata  = ns_rdata + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_SC_RD;
      end
      S_RD_RP: begin
        res_rp_nxt = rp_rdata;
        state_nxt  = S_FIN;
      end
      S_RD_CSR: begin
        res_col_nxt = csr_rdata[CSR_W-1 -: COL_W];
        res_val_nxt = csr_rdata[VAL_W-1:0];
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    num_rows_nxt = num_rows_r;
    if (cfg_wr_en && (entry_count_r == '0) && !built_r) begin
      num_rows_nxt = cfg_wr_data;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      cnt_r         <= '0;
      entry_count_r <= '0;
      built_r       <= 1'b0;
      num_rows_r    <= NR_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      entry_count_r <= entry_count_nxt;
      built_r       <= built_nxt;
      num_rows_r    <= num_rows_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    row_r        <= row_nxt;
    pay_r        <= pay_nxt;
    res_status_r <= res_status_nxt;
    res_rp_r     <= res_rp_nxt;
    res_col_r    <= res_col_nxt;
    res_val_r    <= res_val_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_rp_r     <= res_rp_r;
      out_col_r    <= res_col_r;
      out_val_r    <= res_val_r;
      out_total_r  <= entry_count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_row_pointer = out_rp_r;
  assign out_column      = out_col_r;
  assign out_value       = out_val_r;
  assign out_entry_total = out_total_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(MAX_NNZ))
    else $error("entry count beyond store depth");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("new item taken while the previous one is in progress");

  a_no_load_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD_WR) |-> !built_r)
    else $error("triplet stored after the build");

  a_rows_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(num_rows_r)) |-> ($past(entry_count_r) == '0 && !$past(built_r)))
    else $error("row count changed under loaded data");

endmodule
